// ===== rtl/hkw_pkg.sv =====
// Shared package for the HTTP Host keyword block: constants, reset values,
// register indexes and the structs passed between the front, queue and back.
// No dependencies.
`default_nettype none

package hkw_pkg;

    // Parameter defaults.
    localparam int MAX_PACKET_BYTES_DEF  = 65535;
    localparam int KEYWORD_MAX_BYTES_DEF = 8;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Fixed widths.
    localparam int KW_W    = 64;  // keyword register
    localparam int KLEN_W  = 4;   // keyword length register
    localparam int WIN_W   = 8;   // Host search window register
    localparam int LINE_W  = 16;  // position within the Host line
    localparam int ARITH_W = 17;  // working width for position sums
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KW_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd2;

    // Configuration reset values: a six-byte keyword, length 6, window 60.
    localparam logic [KW_W-1:0]   KW_RESET   = 64'd119199962524007;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd6;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 8'd60;

    // Protocol constants.
    localparam logic [31:0] HOST_WORD     = 32'h486F7374;  // "Host"
    localparam logic [7:0]  CHAR_CR       = 8'h0D;
    localparam logic [7:0]  CHAR_LF       = 8'h0A;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
    localparam int          PROTO_OFFSET  = 9;
    localparam int          HOST_TAIL     = 3;   // offset of 't' from 'H'

    // One classified byte handed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       scan;  // byte lies below the packet size limit
    } t_item;

    // One verdict.
    typedef struct packed {
        logic drop_packet;
        logic is_tcp;
        logic host_seen;
    } t_verdict;

endpackage

`default_nettype wire

// ===== rtl/http_host_keyword_block.sv =====
// HTTP Host keyword filter, top level: configuration registers, front end,
// queue and back end. Depends on hkw_pkg, hkw_front, hkw_queue, hkw_back.
// One packet byte per cycle; the input stalls only once a waiting verdict holds a
// last byte back and the four-entry queue has filled. A last byte passes through the
// queue, and its verdict is then held in the verdict register until it transfers.
// Synchronous active-low reset empties the queue, clears state, loads the defaults.
`default_nettype none

module http_host_keyword_block #(
    parameter int MAX_PACKET_BYTES  = hkw_pkg::MAX_PACKET_BYTES_DEF,
    parameter int KEYWORD_MAX_BYTES = hkw_pkg::KEYWORD_MAX_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Packet byte channel.
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_packet_byte,
    input  wire logic                           i_last_byte,
    // Verdict channel.
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_drop_packet,
    output logic                                o_is_tcp,
    output logic                                o_host_seen,
    // Configuration write channel.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [hkw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hkw_pkg::KW_W-1:0]       i_cfg_data
);

    // Byte offsets within a packet run up to the size limit.
    localparam int OFS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int QW    = OFS_W + $bits(hkw_pkg::t_item);

    logic [hkw_pkg::KW_W-1:0]   r_keyword;
    logic [hkw_pkg::KLEN_W-1:0] r_kw_len;
    logic [hkw_pkg::WIN_W-1:0]  r_window;

    logic               push;
    logic               pop;
    logic               queue_full;
    logic               head_valid;
    hkw_pkg::t_item     front_item;
    hkw_pkg::t_item     head_item;
    logic [OFS_W-1:0]   front_pos;
    logic [OFS_W-1:0]   head_pos;
    logic [QW-1:0]      head_data;
    hkw_pkg::t_verdict  verdict;

    // Configuration writes are always taken. Writes to an index beyond the
    // register list complete the transfer and change nothing.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyword <= hkw_pkg::KW_RESET;
            r_kw_len  <= hkw_pkg::KLEN_RESET;
            r_window  <= hkw_pkg::WIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hkw_pkg::CFG_KEYWORD: r_keyword <= i_cfg_data;
                hkw_pkg::CFG_KW_LEN:  r_kw_len  <= i_cfg_data[hkw_pkg::KLEN_W-1:0];
                hkw_pkg::CFG_WINDOW:  r_window  <= i_cfg_data[hkw_pkg::WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front end tags each byte with its offset and whether it lies below
    // the size limit, then hands it to the queue.
    hkw_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .OFS_W            (OFS_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_packet_byte (i_packet_byte),
        .i_last_byte   (i_last_byte),
        .i_queue_full  (queue_full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_item        (front_item),
        .o_pos         (front_pos)
    );

    // The queue lets the front keep taking bytes while a verdict waits at the
    // output.
    hkw_queue #(
        .WIDTH (QW),
        .DEPTH (hkw_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_pos, front_item}),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .o_data  (head_data)
    );

    assign head_pos  = head_data[QW-1 -: OFS_W];
    assign head_item = hkw_pkg::t_item'(head_data[$bits(hkw_pkg::t_item)-1:0]);

    // The back end runs the header walk, the Host search and the keyword
    // match, and holds the verdict in its output register.
    hkw_back #(
        .KEYWORD_MAX_BYTES (KEYWORD_MAX_BYTES),
        .OFS_W             (OFS_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_item),
        .i_head_pos   (head_pos),
        .o_pop        (pop),
        .i_keyword    (r_keyword),
        .i_kw_len     (r_kw_len),
        .i_window     (r_window),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_verdict    (verdict)
    );

    assign o_drop_packet = verdict.drop_packet;
    assign o_is_tcp      = verdict.is_tcp;
    assign o_host_seen   = verdict.host_seen;

endmodule

`default_nettype wire

// ===== rtl/hkw_front.sv =====
// Front end of the Host keyword block: takes packet bytes, counts the byte
// offset within the packet and tags each byte for the back end.
// Depends on hkw_pkg.
`default_nettype none

module hkw_front #(
    parameter int MAX_PACKET_BYTES = hkw_pkg::MAX_PACKET_BYTES_DEF,
    parameter int OFS_W            = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [7:0]       i_packet_byte,
    input  wire logic             i_last_byte,
    input  wire logic             i_queue_full,
    output logic                  o_in_stall,
    output logic                  o_push,
    output hkw_pkg::t_item        o_item,
    output logic [OFS_W-1:0]      o_pos
);

    localparam logic [OFS_W-1:0] POS_LIMIT = OFS_W'(MAX_PACKET_BYTES);

    logic [OFS_W-1:0] r_pos;
    logic [OFS_W-1:0] n_pos;
    logic             scan;

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;
    assign scan       = (r_pos < POS_LIMIT);

    assign o_item.data = i_packet_byte;
    assign o_item.last = i_last_byte;
    assign o_item.scan = scan;
    assign o_pos       = r_pos;

    // The offset stops counting at the size limit and restarts with each packet.
    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_last_byte) begin
                n_pos = '0;
            end else if (scan) begin
                n_pos = r_pos + OFS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hkw_queue.sv =====
// Short first-in first-out queue between the front and back of the Host
// keyword block. Generic over the entry width.
// Depends on hkw_pkg for its default depth.
`default_nettype none

module hkw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hkw_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hkw_back.sv =====
// Back end of the Host keyword block: walks the IP header, searches for the
// Host line, matches the keyword in it and registers the verdict.
// Depends on hkw_pkg.
`default_nettype none

module hkw_back #(
    parameter int KEYWORD_MAX_BYTES = hkw_pkg::KEYWORD_MAX_BYTES_DEF,
    parameter int OFS_W             = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_head_valid,
    input  wire hkw_pkg::t_item              i_head,
    input  wire logic [OFS_W-1:0]            i_head_pos,
    output logic                             o_pop,
    input  wire logic [hkw_pkg::KW_W-1:0]    i_keyword,
    input  wire logic [hkw_pkg::KLEN_W-1:0]  i_kw_len,
    input  wire logic [hkw_pkg::WIN_W-1:0]   i_window,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output hkw_pkg::t_verdict                o_verdict
);

    localparam int AW = hkw_pkg::ARITH_W;
    localparam int LW = hkw_pkg::LINE_W;
    localparam logic [hkw_pkg::KLEN_W-1:0] KMAX = hkw_pkg::KLEN_W'(KEYWORD_MAX_BYTES);

    typedef enum logic [2:0] {
        PH_IP,
        PH_SEARCH,
        PH_LINE,
        PH_TAIL,
        PH_DONE
    } t_phase;

    // Per-packet state.
    t_phase      r_phase, n_phase;
    logic [3:0]  r_hw, n_hw;
    logic        r_tcp, n_tcp;
    logic        r_host, n_host;
    logic        r_match, n_match;
    logic [63:0] r_recent, n_recent;
    logic [LW-1:0] r_lbc, n_lbc;
    logic [LW-1:0] r_line_end, n_line_end;

    // Keyword realigned to the byte history: lane j holds the keyword byte
    // expected j bytes before the newest one.
    logic [7:0]  r_want [8];
    logic [7:0]  r_mask;
    logic [hkw_pkg::KLEN_W-1:0] r_n;

    logic [hkw_pkg::KLEN_W-1:0] eff_len;
    logic [7:0]  want_c [8];
    logic [7:0]  mask_c;

    logic        r_out_valid;
    hkw_pkg::t_verdict r_verdict;
    hkw_pkg::t_verdict verdict_c;

    logic [63:0] recent_c;
    logic [7:0]  byte_eq;
    logic        bytes_ok;
    logic        kw_hit;
    logic [LW-1:0] lbc_inc;
    logic [LW-1:0] rel_sel;
    logic [3:0]  hw_new;
    logic        tcp_new;
    logic [3:0]  hw_eff;
    logic [5:0]  tcp_start;
    logic [AW-1:0] pos_w, q_w, win_w, s_w, n_w;
    logic        s_neg, lf_end;

    assign o_pop = i_head_valid && (!i_head.last || !r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    // Keyword alignment, refreshed every cycle from the registers.
    always_comb begin
        logic [3:0] idx;
        eff_len = (i_kw_len > KMAX) ? KMAX : i_kw_len;
        for (int j = 0; j < 8; j++) begin
            idx       = eff_len - 4'(j + 1);
            mask_c[j] = (4'(j) < eff_len);
            want_c[j] = i_keyword[8*idx[2:0] +: 8];
        end
    end

    // Matching against the byte history after this byte is shifted in.
    always_comb begin
        recent_c = {r_recent[55:0], i_head.data};
        for (int j = 0; j < 8; j++) begin
            byte_eq[j] = !r_mask[j] || (recent_c[8*j +: 8] == r_want[j]);
        end
        bytes_ok = &byte_eq;
        lbc_inc  = (r_lbc != {LW{1'b1}}) ? r_lbc + LW'(1) : r_lbc;
        rel_sel  = (r_phase == PH_SEARCH) ? LW'(hkw_pkg::HOST_TAIL) : lbc_inc;
        kw_hit   = (r_n != '0) && ((AW'(rel_sel) + AW'(1)) >= AW'(r_n)) && bytes_ok;
    end

    // Header fields and position arithmetic.
    always_comb begin
        pos_w   = AW'(i_head_pos);
        hw_new  = (r_phase == PH_IP && pos_w == '0) ? i_head.data[3:0] : r_hw;
        tcp_new = (r_phase == PH_IP && pos_w == AW'(hkw_pkg::PROTO_OFFSET))
                  ? (i_head.data == hkw_pkg::PROTO_TCP) : r_tcp;
        hw_eff  = (hw_new < hkw_pkg::MIN_HDR_WORDS) ? hkw_pkg::MIN_HDR_WORDS : hw_new;
        tcp_start = {hw_eff, 2'b00};
        q_w     = pos_w - AW'(tcp_start);
        win_w   = AW'(i_window);
        n_w     = AW'(r_n);
        // Start of a keyword ending at the newest byte; below zero counts as
        // past the line end.
        s_neg   = (AW'(lbc_inc) + AW'(1)) < n_w;
        s_w     = AW'(lbc_inc) + AW'(1) - n_w;
        lf_end  = (i_head.data == hkw_pkg::CHAR_LF) && (recent_c[15:8] == hkw_pkg::CHAR_CR);
    end

    always_comb begin
        n_phase    = r_phase;
        n_hw       = r_hw;
        n_tcp      = r_tcp;
        n_host     = r_host;
        n_match    = r_match;
        n_recent   = r_recent;
        n_lbc      = r_lbc;
        n_line_end = r_line_end;

        if (o_pop && i_head.scan) begin
            n_recent = recent_c;
            unique case (r_phase)
                PH_IP: begin
                    n_hw  = hw_new;
                    n_tcp = tcp_new;
                    if (pos_w == AW'(hkw_pkg::PROTO_OFFSET) && !tcp_new) begin
                        n_phase = PH_DONE;
                    end
                    if (tcp_new && pos_w >= AW'(hkw_pkg::PROTO_OFFSET) &&
                        (pos_w + AW'(1)) == AW'(tcp_start)) begin
                        n_phase = PH_SEARCH;
                    end
                end
                PH_SEARCH: begin
                    if (q_w >= AW'(hkw_pkg::HOST_TAIL) &&
                        (q_w - AW'(hkw_pkg::HOST_TAIL)) < win_w &&
                        recent_c[31:0] == hkw_pkg::HOST_WORD) begin
                        n_host  = 1'b1;
                        n_lbc   = LW'(hkw_pkg::HOST_TAIL);
                        n_phase = PH_LINE;
                        if (kw_hit) begin
                            n_match = 1'b1;
                        end
                    end else if ((q_w + AW'(1)) >= (win_w + AW'(hkw_pkg::HOST_TAIL))) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_LINE: begin
                    n_lbc = lbc_inc;
                    if (lf_end) begin
                        // The keyword may not start on the LF itself.
                        n_line_end = lbc_inc - LW'(1);
                        if (r_n >= 4'd2 && kw_hit) begin
                            n_match = 1'b1;
                        end
                        n_phase = (r_n >= 4'd3) ? PH_TAIL : PH_DONE;
                    end else if (kw_hit) begin
                        n_match = 1'b1;
                    end
                end
                PH_TAIL: begin
                    n_lbc = lbc_inc;
                    if (!s_neg && s_w <= AW'(r_line_end) && kw_hit) begin
                        n_match = 1'b1;
                    end
                    if (s_neg || s_w >= AW'(r_line_end)) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end

        verdict_c.drop_packet = n_tcp & n_match;
        verdict_c.is_tcp      = n_tcp;
        verdict_c.host_seen   = n_host;

        if (o_pop && i_head.last) begin
            n_phase    = PH_IP;
            n_hw       = '0;
            n_tcp      = 1'b0;
            n_host     = 1'b0;
            n_match    = 1'b0;
            n_recent   = '0;
            n_lbc      = '0;
            n_line_end = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_want    <= want_c;
        r_mask    <= mask_c;
        r_n       <= eff_len;
        if (o_pop && i_head.last) begin
            r_verdict <= verdict_c;
        end
        if (!i_rst_n) begin
            r_phase     <= PH_IP;
            r_hw        <= '0;
            r_tcp       <= 1'b0;
            r_host      <= 1'b0;
            r_match     <= 1'b0;
            r_recent    <= '0;
            r_lbc       <= '0;
            r_line_end  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hw       <= n_hw;
            r_tcp      <= n_tcp;
            r_host     <= n_host;
            r_match    <= n_match;
            r_recent   <= n_recent;
            r_lbc      <= n_lbc;
            r_line_end <= n_line_end;
            if (o_pop && i_head.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_http_host_keyword_block.sv =====
// Self-checking testbench for the HTTP Host keyword filter: packets go in a byte at a time
// and each verdict is checked against a predictor kept in step inside the bench.
// Depends on hkw_pkg and http_host_keyword_block.
`default_nettype none

module tb_http_host_keyword_block;

    import hkw_pkg::*;

    localparam int MAX_BYTES    = MAX_PACKET_BYTES_DEF;
    localparam int KW_BYTES_MAX = KEYWORD_MAX_BYTES_DEF;
    localparam int DRAIN_CYCLES = 8;        // settle time once no predicted verdict is left
    localparam int HOLD_CYCLES  = 300;      // length of the long verdict hold-off
    localparam int CYCLE_LIMIT  = 1000000;  // the slowest legal run is well below this

    // Scan phases of the predictor, one per stage of the walk through a packet.
    typedef enum logic [2:0] {
        SCAN_IP,
        SCAN_SEARCH,
        SCAN_LINE,
        SCAN_TAIL,
        SCAN_DONE
    } t_scan_st;

    // Block ports. Every input has a known value from time zero.
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_packet_byte = 8'h00;
    logic                 i_last_byte   = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall   = 1'b0;
    logic                 o_drop_packet;
    logic                 o_is_tcp;
    logic                 o_host_seen;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_KEYWORD;
    logic [KW_W-1:0]      i_cfg_data    = '0;

    // Copy of the configuration registers as the predictor sees them.
    logic [KW_W-1:0]   kw_reg;
    logic [KLEN_W-1:0] kw_len_reg;
    logic [WIN_W-1:0]  win_reg;

    // Per-packet state of the predictor.
    logic [15:0]     byte_pos;
    logic [3:0]      hdr_words;
    logic            proto_tcp;
    t_scan_st        scan_st;
    logic [63:0]     last8;       // last eight bytes, newest in the low byte
    logic [LINE_W-1:0] line_pos;  // position relative to the 'H' of Host
    logic            host_found;
    logic            kw_found;
    logic [LINE_W-1:0] cr_pos;    // position of the CR relative to the 'H'

    // Verdicts predicted but not yet seen on the output.
    t_verdict verdict_q[$];

    // Packet under construction, first byte at index zero.
    logic [7:0] pkt[$];

    int idle_pct     = 0;   // chance in a hundred that the sender idles a cycle
    int stall_pct    = 0;   // chance in a hundred that the receiver stalls a cycle
    bit hold_req     = 1'b0;
    int hold_left    = 0;
    int setting_no   = 0;
    int cycle_count  = 0;
    int fail_count   = 0;

    http_host_keyword_block DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_packet_byte (i_packet_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_drop_packet (o_drop_packet),
        .o_is_tcp      (o_is_tcp),
        .o_host_seen   (o_host_seen),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic clear_packet_state();
        byte_pos   = '0;
        hdr_words  = '0;
        proto_tcp  = 1'b0;
        scan_st    = SCAN_IP;
        last8      = '0;
        line_pos   = '0;
        host_found = 1'b0;
        kw_found   = 1'b0;
        cr_pos     = '0;
    endtask

    // Lengths above the supported maximum are clipped; zero stays zero and never matches.
    function automatic int unsigned kw_len_eff();
        int unsigned n;
        n = kw_len_reg;
        if (n > KW_BYTES_MAX) n = KW_BYTES_MAX;
        return n;
    endfunction

    // True when the keyword ends at the newest byte and starts no earlier than the 'H'.
    function automatic bit keyword_ends_here(input int unsigned rel);
        int unsigned n;
        n = kw_len_eff();
        if (n == 0 || rel + 1 < n) return 1'b0;
        for (int unsigned k = 0; k < n; k++) begin
            if (kw_reg[8*k +: 8] != last8[8*(n-1-k) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the predictor by one accepted byte and, on the last byte of a packet,
    // queues the verdict that the block must give. Arithmetic is 32-bit unsigned so that
    // the differences wrap exactly as the block's definition requires.
    task automatic filter_byte(input logic [7:0] b, input logic is_last);
        int unsigned pos, hw, tcp_start, n, q, s, win;
        bit          lf_end;
        t_verdict    v;
        if (byte_pos < MAX_BYTES) begin
            pos       = byte_pos;
            hw        = (hdr_words < MIN_HDR_WORDS) ? MIN_HDR_WORDS : hdr_words;
            tcp_start = hw * 4;
            n         = kw_len_eff();
            win       = win_reg;
            last8     = {last8[55:0], b};
            case (scan_st)
                SCAN_IP: begin
                    if (pos == 0) hdr_words = b[3:0];
                    if (pos == PROTO_OFFSET) begin
                        proto_tcp = (b == PROTO_TCP);
                        if (!proto_tcp) scan_st = SCAN_DONE;
                    end
                    hw        = (hdr_words < MIN_HDR_WORDS) ? MIN_HDR_WORDS : hdr_words;
                    tcp_start = hw * 4;
                    if (proto_tcp && pos >= PROTO_OFFSET && pos + 1 == tcp_start)
                        scan_st = SCAN_SEARCH;
                end
                SCAN_SEARCH: begin
                    q = pos - tcp_start;
                    if (q >= HOST_TAIL && q - HOST_TAIL < win && last8[31:0] == HOST_WORD) begin
                        host_found = 1'b1;
                        line_pos   = LINE_W'(HOST_TAIL);
                        scan_st    = SCAN_LINE;
                        if (keyword_ends_here(line_pos)) kw_found = 1'b1;
                    end else if (q + 1 >= win + HOST_TAIL) begin
                        scan_st = SCAN_DONE;
                    end
                end
                SCAN_LINE: begin
                    if (line_pos != '1) line_pos = line_pos + 1'b1;
                    lf_end = (b == CHAR_LF) && (last8[15:8] == CHAR_CR);
                    if (lf_end) begin
                        // A keyword may begin at the CR but not at the LF.
                        cr_pos = line_pos - 1'b1;
                        if (n >= 2 && keyword_ends_here(line_pos)) kw_found = 1'b1;
                        scan_st = (n >= 3) ? SCAN_TAIL : SCAN_DONE;
                    end else if (keyword_ends_here(line_pos)) begin
                        kw_found = 1'b1;
                    end
                end
                SCAN_TAIL: begin
                    // Bytes past the LF only finish a keyword that started by the CR.
                    if (line_pos != '1) line_pos = line_pos + 1'b1;
                    s = line_pos + 1 - n;
                    if (s <= cr_pos && keyword_ends_here(line_pos)) kw_found = 1'b1;
                    if (s >= cr_pos) scan_st = SCAN_DONE;
                end
                default: ;
            endcase
            byte_pos = byte_pos + 1'b1;
        end
        if (is_last) begin
            v.drop_packet = proto_tcp & kw_found;
            v.is_tcp      = proto_tcp;
            v.host_seen   = host_found;
            verdict_q.push_back(v);
            clear_packet_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offers one byte, after a random number of idle cycles, and holds it until the
    // transfer happens. The stall seen at the wake-up edge is its value before that edge.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_packet_byte <= b;
        i_last_byte   <= is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        filter_byte(b, is_last);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Stops offering bytes and waits until every predicted verdict has been transferred,
    // then lets the pipeline settle.
    task automatic drain_verdicts();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Valid is left high after the transfer so that back-to-back writes need no gap;
    // the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KW_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_KEYWORD: kw_reg     = data;
            CFG_KW_LEN:  kw_len_reg = data[KLEN_W-1:0];
            CFG_WINDOW:  win_reg    = data[WIN_W-1:0];
            default: ;
        endcase
    endtask

    // Rewrites all three registers once the block is idle. The unused upper data bits
    // carry random values, which the block must ignore.
    task automatic set_regs(input logic [KW_W-1:0] kw, input logic [KLEN_W-1:0] len,
                            input logic [WIN_W-1:0] win);
        logic [KW_W-1:0] data;
        drain_verdicts();
        write_reg(CFG_KEYWORD, kw);
        data = {$urandom, $urandom};
        data[KLEN_W-1:0] = len;
        write_reg(CFG_KW_LEN, data);
        data = {$urandom, $urandom};
        data[WIN_W-1:0] = win;
        write_reg(CFG_WINDOW, data);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Packet building
    // ------------------------------------------------------------------

    function automatic logic [KW_W-1:0] kw_of(input string str);
        logic [KW_W-1:0] v;
        v = '0;
        for (int i = 0; i < str.len() && i < 8; i++) v[8*i +: 8] = str[i];
        return v;
    endfunction

    // The first count bytes of a keyword register as text.
    function automatic string kw_text(input logic [KW_W-1:0] kw, input int count);
        string str;
        str = "";
        for (int i = 0; i < count; i++) str = $sformatf("%s%c", str, kw[8*i +: 8]);
        return str;
    endfunction

    // IPv4 header with the given length field and protocol; a length field below five
    // still gets a twenty-byte header, since that is where the block looks for TCP.
    task automatic start_packet(input logic [3:0] hl, input logic [7:0] proto);
        int unsigned hdr_len;
        hdr_len = int'((hl < MIN_HDR_WORDS) ? MIN_HDR_WORDS : hl) * 4;
        pkt.delete();
        pkt.push_back({4'h4, hl});
        for (int unsigned i = 1; i < hdr_len; i++)
            pkt.push_back((i == PROTO_OFFSET) ? proto : 8'($urandom));
    endtask

    task automatic add_str(input string str);
        for (int i = 0; i < str.len(); i++) pkt.push_back(str[i]);
    endtask

    task automatic add_fill(input int count);
        repeat (count) pkt.push_back(8'h2E);
    endtask

    task automatic trim_packet(input int keep);
        while (pkt.size() > keep) void'(pkt.pop_back());
    endtask

    // A TCP packet whose Host starts pre positions after the TCP header start.
    task automatic host_packet(input int pre, input string line);
        start_packet(4'd5, PROTO_TCP);
        add_fill(pre);
        add_str("Host");
        add_str(line);
        send_packet();
    endtask

    // Bytes for a Host line, biased towards keyword bytes, line ends and Host letters
    // so that near misses and partial matches are common.
    function automatic logic [7:0] line_byte();
        int unsigned r, n, idx;
        n = kw_len_eff();
        r = $urandom_range(0, 99);
        if (r < 40 && n > 0) begin
            idx = $urandom_range(0, n - 1);
            return kw_reg[8*idx +: 8];
        end
        if (r < 50) return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
        if (r < 60) begin
            idx = $urandom_range(0, 3);
            return HOST_WORD[8*idx +: 8];
        end
        return 8'($urandom);
    endfunction

    // Mostly well-formed packets with random content; the rest are noise or are cut off
    // part way through.
    task automatic random_packet();
        int unsigned kind, pre, limit, n, cnt, idx;
        logic [3:0]  hl;
        logic [7:0]  proto;
        kind  = $urandom_range(0, 99);
        hl    = ($urandom_range(0, 3) == 0) ? 4'($urandom) : MIN_HDR_WORDS;
        proto = ($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_TCP;
        if (kind < 85) begin
            start_packet(hl, proto);
            limit = int'(win_reg) + 2;
            if (limit > 45) limit = 45;
            pre = $urandom_range(0, limit);
            repeat (pre) begin
                idx = $urandom_range(0, 3);
                pkt.push_back(($urandom_range(0, 3) == 0) ? HOST_WORD[8*idx +: 8]
                                                           : 8'($urandom));
            end
            add_str("Host");
            repeat ($urandom_range(0, 8)) pkt.push_back(line_byte());
            n = kw_len_eff();
            if (n > 0 && $urandom_range(0, 9) < 6) begin
                cnt = $urandom_range(1, n);
                for (int unsigned k = 0; k < cnt; k++) pkt.push_back(kw_reg[8*k +: 8]);
            end
            repeat ($urandom_range(0, 4)) pkt.push_back(line_byte());
            if ($urandom_range(0, 99) < 85) begin
                pkt.push_back(CHAR_CR);
                pkt.push_back(CHAR_LF);
                repeat ($urandom_range(0, 8)) pkt.push_back(line_byte());
            end
            if ($urandom_range(0, 6) == 0) trim_packet($urandom_range(1, pkt.size()));
        end else begin
            pkt.delete();
            repeat ($urandom_range(1, 40)) pkt.push_back(line_byte());
        end
        send_packet();
    endtask

    // Cycles through the register extremes as well as random settings.
    task automatic pick_setting(input int num);
        logic [KW_W-1:0] kw;
        int unsigned     r;
        for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0)      kw[8*i +: 8] = CHAR_CR;
            else if (r == 1) kw[8*i +: 8] = CHAR_LF;
            else if (r < 5)  kw[8*i +: 8] = HOST_WORD[8*$urandom_range(0, 3) +: 8];
            else             kw[8*i +: 8] = 8'($urandom);
        end
        case (num % 6)
            0: set_regs({$urandom, $urandom}, 4'd8, 8'd255);
            1: set_regs(kw, 4'd1, 8'd1);
            2: set_regs('0, 4'd0, 8'($urandom_range(0, 40)));
            3: set_regs(kw, 4'($urandom_range(9, 15)), 8'($urandom_range(1, 40)));
            4: set_regs('1, 4'($urandom_range(1, 8)), 8'($urandom_range(1, 40)));
            default: set_regs(kw, 4'($urandom_range(1, 8)), 8'($urandom_range(1, 40)));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Runs at the reset configuration: the reset keyword, length six, window sixty.
    task automatic test_reset_config();
        string kw;
        kw = kw_text(KW_RESET, int'(KLEN_RESET));
        host_packet(8, {": www.", kw, ".net\015\012abc"});
        // A non-TCP packet is accepted even with the keyword in it.
        start_packet(4'd5, 8'd17);
        add_str({"Host: ", kw, "\015\012"});
        send_packet();
        // Packets that end before or at the protocol byte.
        start_packet(4'd5, PROTO_TCP);
        trim_packet(6);
        send_packet();
        start_packet(4'd5, PROTO_TCP);
        trim_packet(10);
        send_packet();
        pkt.delete();
        pkt.push_back(8'hFF);
        send_packet();
        // A header length below five is taken as five; the line here never ends.
        start_packet(4'd0, PROTO_TCP);
        add_str({"Host: ", kw});
        send_packet();
        // The longest header.
        start_packet(4'd15, PROTO_TCP);
        add_fill(3);
        add_str({"Host:", kw, "\015\012"});
        send_packet();
        // Host at the last start position of the window and just past it.
        host_packet(59, {": ", kw, "\015\012"});
        host_packet(60, {": ", kw, "\015\012"});
    endtask

    // Keywords around the CR LF that ends the Host line.
    task automatic test_line_end();
        set_regs(kw_of("ab\015\012xy"), 4'd6, 8'd60);
        host_packet(2, ": zab\015\012xyq");
        set_regs(kw_of("\015\012"), 4'd2, 8'd60);
        host_packet(0, ": a\015\012");
        set_regs(kw_of("\012xyz"), 4'd4, 8'd60);
        host_packet(0, ": a\015\012xyz");
        set_regs(kw_of("\015\012xyz"), 4'd5, 8'd60);
        host_packet(0, ": a\015\012xyz");
        set_regs(kw_of("banned"), 4'd6, 8'd60);
        host_packet(0, ": a\015\012banned");
    endtask

    task automatic test_keyword_length();
        set_regs(kw_of("banned"), 4'd0, 8'd60);
        host_packet(0, ": banned\015\012");
        // Lengths above eight act as eight.
        set_regs(kw_of("abcdefgh"), 4'd12, 8'd60);
        host_packet(0, ": abcdefgh\015\012");
        host_packet(0, ": abcdefg\015\012");
        // A one-byte keyword can match on the 't' of Host itself.
        set_regs(kw_of("t"), 4'd1, 8'd60);
        host_packet(0, ": x");
        set_regs('1, 4'd8, 8'd60);
        host_packet(1, ":\377\377\377\377\377\377\377\377");
    endtask

    task automatic test_window();
        // With a window of zero no Host is ever searched for.
        set_regs(kw_of("banned"), 4'd6, 8'd0);
        host_packet(0, ": banned\015\012");
        set_regs(kw_of("banned"), 4'd6, 8'd1);
        host_packet(0, ": banned\015\012");
        host_packet(1, ": banned\015\012");
        set_regs(kw_of("banned"), 4'd6, 8'd255);
        host_packet(254, ": banned\015\012");
        host_packet(255, ": banned\015\012");
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering short
    // packets, so that the internal queue fills and the block stalls its input.
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        repeat (30) begin
            pkt.delete();
            repeat (3) pkt.push_back(8'($urandom));
            send_packet();
        end
        drain_verdicts();
    endtask

    // Random traffic under two register settings with the given idling.
    task automatic test_random_traffic(input int sender_idle, input int receiver_stall);
        int sent_bytes, sent_pkts;
        for (int s = 0; s < 2; s++) begin
            pick_setting(setting_no);
            setting_no++;
            idle_pct   = sender_idle;
            stall_pct  = receiver_stall;
            sent_bytes = 0;
            sent_pkts  = 0;
            while (sent_bytes < 60 || sent_pkts < 2) begin
                random_packet();
                sent_bytes += pkt.size();
                sent_pkts++;
            end
        end
        drain_verdicts();
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Random stalls on the verdict channel, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Every transferred verdict is compared with the oldest prediction. Values are taken
    // before the edge's updates, so the order of processes within the step does not matter.
    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("cycle %0d: verdict with none expected: drop=%b tcp=%b host=%b",
                             cycle_count, o_drop_packet, o_is_tcp, o_host_seen);
            end else begin
                want = verdict_q.pop_front();
                if (o_drop_packet !== want.drop_packet || o_is_tcp !== want.is_tcp ||
                    o_host_seen !== want.host_seen) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"cycle %0d: verdict mismatch: expected drop=%b tcp=%b ",
                                  "host=%b, got drop=%b tcp=%b host=%b"}, cycle_count,
                                 want.drop_packet, want.is_tcp, want.host_seen,
                                 o_drop_packet, o_is_tcp, o_host_seen);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        kw_reg     = KW_RESET;
        kw_len_reg = KLEN_RESET;
        win_reg    = WIN_RESET;
        clear_packet_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_config();
        test_line_end();
        test_keyword_length();
        test_window();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(63, 0);
        test_random_traffic(0, 63);
        test_random_traffic(33, 33);

        drain_verdicts();
        fail_count += verdict_q.size();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/hkw_pkg.sv
rtl/hkw_front.sv
rtl/hkw_queue.sv
rtl/hkw_back.sv
rtl/http_host_keyword_block.sv
tb/sv/tb_http_host_keyword_block.sv
